### hw/rtl/grru_pkg.sv
package grru_pkg;

    // Fixed widths of the stream words and of the configuration register.
    localparam int DATA_W = 32;
    localparam int CFG_W  = 5;
    localparam int APB_W  = 32;
    localparam int ADDR_W = 3;

    // Default group buffer depth and the reset group size.
    localparam int             MAX_GROUP_DEF    = 16;
    localparam logic [CFG_W-1:0] GROUP_SIZE_RESET = 5'd2;

    // Register index carried in paddr[2].
    localparam logic REG_GROUP_SIZE = 1'b0;

    // Bank release from the back end to the front end.
    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

    // Width of one group command: bank, reverse flag, stream end flag, count.
    function automatic int cmd_width(input int max_group);
        return $clog2(max_group + 1) + 3;
    endfunction

endpackage

### hw/rtl/grru_ram.sv
module grru_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/grru_front.sv
module grru_front import grru_pkg::*; #(
    parameter int MAX_GROUP = MAX_GROUP_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [CFG_W-1:0]                    i_group_size,
    input  logic                                i_s_valid,
    output logic                                o_s_ready,
    input  logic [DATA_W-1:0]                   i_s_data,
    input  logic                                i_s_last,
    output logic                                o_wr_en,
    output logic [$clog2(MAX_GROUP):0]          o_wr_addr,
    output logic [DATA_W-1:0]                   o_wr_data,
    output logic                                o_cmd_push,
    output logic [cmd_width(MAX_GROUP)-1:0]     o_cmd,
    input  logic                                i_cmd_full,
    input  t_release                            i_release
);

    localparam int IW = $clog2(MAX_GROUP);
    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int SW = (CW > CFG_W) ? CW : CFG_W;

    typedef struct packed {
        logic          bank;
        logic          rev;
        logic          stream_end;
        logic [CW-1:0] count;
    } t_cmd;

    logic [IW-1:0] r_fill, n_fill;
    logic          r_bank, n_bank;
    logic [1:0]    r_busy, n_busy;

    logic [SW-1:0] size_ext;
    logic [SW-1:0] size_eff;
    logic [SW-1:0] count_ext;
    logic          pass_mode;
    logic          group_full;
    logic          emit;
    logic          accept;
    t_cmd          cmd;

    assign size_ext  = SW'(i_group_size);
    assign size_eff  = (size_ext > SW'(MAX_GROUP)) ? SW'(MAX_GROUP) : size_ext;
    assign count_ext = SW'(r_fill) + SW'(1);
    assign pass_mode = size_eff < SW'(2);
    assign group_full = count_ext >= size_eff;
    assign emit      = pass_mode || group_full || i_s_last;

    assign o_s_ready = !r_busy[r_bank] && !i_cmd_full;
    assign accept    = i_s_valid && o_s_ready;

    // Every word is stored; pass-through simply replays the group in order.
    assign o_wr_en   = accept;
    assign o_wr_addr = {r_bank, r_fill};
    assign o_wr_data = i_s_data;

    always_comb begin
        cmd.bank       = r_bank;
        cmd.rev        = !pass_mode && group_full;
        cmd.stream_end = i_s_last;
        cmd.count      = CW'(count_ext);
    end

    assign o_cmd      = cmd;
    assign o_cmd_push = accept && emit;

    always_comb begin
        n_fill = r_fill;
        n_bank = r_bank;
        n_busy = r_busy;
        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end
        if (accept) begin
            if (emit) begin
                n_fill         = '0;
                n_bank         = !r_bank;
                n_busy[r_bank] = 1'b1;
            end else begin
                n_fill = r_fill + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_bank <= 1'b0;
            r_busy <= '0;
        end else begin
            r_fill <= n_fill;
            r_bank <= n_bank;
            r_busy <= n_busy;
        end
    end

endmodule

### hw/rtl/grru_cmd_fifo.sv
module grru_cmd_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, n_wp;
    logic             r_rp, n_rp;
    logic [1:0]       r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wp  = do_push ? !r_wp : r_wp;
        n_rp  = do_pop ? !r_rp : r_rp;
        n_cnt = r_cnt + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

### hw/rtl/grru_back.sv
module grru_back import grru_pkg::*; #(
    parameter int MAX_GROUP = MAX_GROUP_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_valid,
    input  logic [cmd_width(MAX_GROUP)-1:0] i_cmd,
    output logic                            o_cmd_pop,
    output logic                            o_rd_en,
    output logic [$clog2(MAX_GROUP):0]      o_rd_addr,
    input  logic [DATA_W-1:0]               i_rd_data,
    output t_release                        o_release,
    output logic                            o_m_valid,
    input  logic                            i_m_ready,
    output logic [DATA_W-1:0]               o_m_data,
    output logic                            o_m_last,
    output logic                            o_m_user
);

    localparam int IW = $clog2(MAX_GROUP);
    localparam int CW = $clog2(MAX_GROUP + 1);

    typedef struct packed {
        logic          bank;
        logic          rev;
        logic          stream_end;
        logic [CW-1:0] count;
    } t_cmd;

    t_cmd          r_cmd;
    logic          r_active, n_active;
    logic [IW-1:0] r_k, n_k;

    logic          r_s1_valid, n_s1_valid;
    logic          r_s1_last;
    logic          r_s1_end;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_last;
    logic              r_out_end;

    logic          out_free;
    logic          issue;
    logic          load;
    logic [CW-1:0] count_m1;
    logic [IW-1:0] last_k;
    logic          at_last;
    logic [IW-1:0] rd_idx;

    assign out_free = !r_out_valid || i_m_ready;
    assign issue    = r_active && (!r_s1_valid || out_free);
    assign load     = !r_active && i_cmd_valid;
    assign o_cmd_pop = load;

    assign count_m1 = r_cmd.count - CW'(1);
    assign last_k   = count_m1[IW-1:0];
    assign at_last  = (r_k == last_k);
    assign rd_idx   = r_cmd.rev ? (last_k - r_k) : r_k;

    assign o_rd_en   = issue;
    assign o_rd_addr = {r_cmd.bank, rd_idx};

    // The bank is free once its final word has been read out of the RAM.
    assign o_release.valid = issue && at_last;
    assign o_release.bank  = r_cmd.bank;

    always_comb begin
        n_active = r_active;
        n_k      = r_k;
        if (load) begin
            n_active = 1'b1;
            n_k      = '0;
        end else if (issue) begin
            if (at_last) begin
                n_active = 1'b0;
            end else begin
                n_k = r_k + IW'(1);
            end
        end
        if (issue) begin
            n_s1_valid = 1'b1;
        end else if (out_free) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_cmd;
        end
        if (issue) begin
            r_s1_last <= at_last;
            r_s1_end  <= at_last && r_cmd.stream_end;
        end
        if (out_free) begin
            r_out_data <= i_rd_data;
            r_out_last <= r_s1_last;
            r_out_end  <= r_s1_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_k         <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active   <= n_active;
            r_k        <= n_k;
            r_s1_valid <= n_s1_valid;
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_data  = r_out_data;
    assign o_m_last  = r_out_last;
    assign o_m_user  = r_out_end;

endmodule

### hw/rtl/group_reverse_reorder_unit.sv
// Channel        | Direction | Handshake             | Payload
// ---------------+-----------+-----------------------+-----------------------------------
// s_axis (input) | in        | tvalid / tready       | tdata = value, tlast = stream end
// m_axis (output)| out       | tvalid / tready       | tdata = value, tlast = run last,
//                |           |                       | tuser = stream end
// APB config     | in        | psel / penable        | register 0 = group size (5 bits)
//
// Each input word is written into one of two group banks in the cycle it is accepted.
// A word that closes a group, ends the stream or arrives in pass-through mode hands a
// command to the back end, which then reads the group out of the RAM at one word per
// cycle while the output is not stalled, and pauses between groups to load the next command.
// The input stalls while the bank it would write still waits to be read out or while the
// command queue is full, so one group can be collected while the previous one is delivered.
// Reset is synchronous and active low; it empties both banks and the command queue and
// sets the group size to two. The buffer itself is not cleared.
// A stalled output holds its word; the read pipeline behind it stops with it.
module group_reverse_reorder_unit import grru_pkg::*; #(
    parameter int MAX_GROUP = MAX_GROUP_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input stream.
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [DATA_W-1:0] i_s_axis_tdata,   // [31:0] in_value
    input  logic              i_s_axis_tlast,   // in_stream_end
    // Output stream.
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [DATA_W-1:0] o_m_axis_tdata,   // [31:0] out_value
    output logic              o_m_axis_tlast,   // out_run_last
    output logic              o_m_axis_tuser,   // [0] out_stream_end
    // Configuration port.
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [APB_W-1:0]  i_pwdata,
    output logic [APB_W-1:0]  o_prdata,
    output logic              o_pready
);

    localparam int AW    = $clog2(MAX_GROUP) + 1;
    localparam int CMD_W = cmd_width(MAX_GROUP);

    // Configuration register. Only paddr[2] selects; the low address bits are ignored.
    logic [CFG_W-1:0] r_group_size;
    logic             cfg_write;

    assign o_pready  = 1'b1;
    assign cfg_write = i_psel && i_penable && i_pwrite && o_pready
                       && (i_paddr[2] == REG_GROUP_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= GROUP_SIZE_RESET;
        end else if (cfg_write) begin
            r_group_size <= i_pwdata[CFG_W-1:0];
        end
    end

    assign o_prdata = (i_paddr[2] == REG_GROUP_SIZE) ? APB_W'(r_group_size) : '0;

    // Signals between the front end, the queue, the RAM and the back end.
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              cmd_push;
    logic [CMD_W-1:0]  cmd_in;
    logic              cmd_full;
    logic              cmd_pop;
    logic              cmd_valid;
    logic [CMD_W-1:0]  cmd_out;
    t_release          release_bank;

    grru_front #(
        .MAX_GROUP(MAX_GROUP)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_group_size (r_group_size),
        .i_s_valid    (i_s_axis_tvalid),
        .o_s_ready    (o_s_axis_tready),
        .i_s_data     (i_s_axis_tdata),
        .i_s_last     (i_s_axis_tlast),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_cmd_push   (cmd_push),
        .o_cmd        (cmd_in),
        .i_cmd_full   (cmd_full),
        .i_release    (release_bank)
    );

    grru_cmd_fifo #(
        .WIDTH(CMD_W)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_data  (cmd_out)
    );

    // Two banks of MAX_GROUP words; the bank is the top address bit.
    grru_ram #(
        .WIDTH(DATA_W),
        .DEPTH(2 * MAX_GROUP)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    grru_back #(
        .MAX_GROUP(MAX_GROUP)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_release   (release_bank),
        .o_m_valid   (o_m_axis_tvalid),
        .i_m_ready   (i_m_axis_tready),
        .o_m_data    (o_m_axis_tdata),
        .o_m_last    (o_m_axis_tlast),
        .o_m_user    (o_m_axis_tuser)
    );

endmodule

### hw/rtl/grru_checker.sv
module grru_checker import grru_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_m_axis_tvalid,
    input logic              i_m_axis_tready,
    input logic [DATA_W-1:0] o_m_axis_tdata,
    input logic              o_m_axis_tlast,
    input logic              o_m_axis_tuser,
    input logic              i_psel,
    input logic              i_penable,
    input logic              i_pwrite,
    input logic [ADDR_W-1:0] i_paddr,
    input logic [APB_W-1:0]  i_pwdata,
    input logic [APB_W-1:0]  o_prdata,
    input logic              o_pready
);

    // The stream end flag only ever sits on the last word of a run.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> o_m_axis_tlast)
        else $error("stream end seen on a word that does not close its run");

    // A stalled output word holds its value and its flags.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)
         && $stable(o_m_axis_tuser)))
        else $error("stalled output word changed");

    // A write to the group size register reads back on the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_psel && i_penable && i_pwrite && o_pready
         && (i_paddr[2] == REG_GROUP_SIZE)) |=>
        ((i_paddr[2] != REG_GROUP_SIZE)
         || (o_prdata[CFG_W-1:0] == $past(i_pwdata[CFG_W-1:0]))))
        else $error("group size register did not take the written value");

    // Read data above the register width is always zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_prdata[APB_W-1:CFG_W] == '0)
        else $error("unused read data bits are set");

endmodule

bind group_reverse_reorder_unit grru_checker u_grru_checker (.*);
